// ===== design/lmfw_pkg.sv =====
package lmfw_pkg;

  // Default sizes of the lock table and of each wait queue.
  localparam int LockCountDef  = 64;
  localparam int QueueDepthDef = 16;

  // Fixed field widths of the request and result.
  localparam int LockIdxW = 6;
  localparam int ClientW  = 4;
  localparam int StatusW  = 2;

  typedef enum logic [StatusW-1:0] {
    StOk         = 2'd0,
    StRetry      = 2'd1,
    StWrongOwner = 2'd2,
    StQueueFull  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SClear,
    SIdle,
    SEntry,
    SWaiter
  } state_e;

endpackage

// ===== design/lock_manager_fifo_waiters_core.sv =====
// Lock manager with a per-lock FIFO of waiting clients. On a request transfer the
// lock's entry is read from the lock table memory into the entry register; it is
// then evaluated and written back, and the result register is loaded. A release
// that hands the lock to a waiter first reads the queue head from the waiter
// memory. A new request is taken in the cycle after the write-back, so the block
// takes no new request before it is through with the last one, and it stalls as
// long as the result register is not drained. After reset the block clears the
// lock table, one entry per cycle, and takes no request until it is cleared.
module lock_manager_fifo_waiters_core #(
  parameter int LOCK_COUNT  = lmfw_pkg::LockCountDef,
  parameter int QUEUE_DEPTH = lmfw_pkg::QueueDepthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               kind_i,
  input  logic [lmfw_pkg::LockIdxW-1:0]      lock_index_i,
  input  logic [lmfw_pkg::ClientW-1:0]       client_i,
  input  logic                               revoke_reply_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [lmfw_pkg::StatusW-1:0]       status_o,
  output logic                               revoke_sent_o,
  output logic [lmfw_pkg::ClientW-1:0]       revoke_target_o,
  output logic                               retry_sent_o,
  output logic [lmfw_pkg::ClientW-1:0]       retry_target_o
);
  import lmfw_pkg::*;

  localparam int LW = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SD = LOCK_COUNT * QUEUE_DEPTH;
  localparam int SW = (SD > 1) ? $clog2(SD) : 1;
  localparam int EW = 1 + ClientW + HW + CW;

  // Memories.
  logic [EW-1:0]      ent_mem [LOCK_COUNT];
  logic [ClientW-1:0] wait_mem [SD];

  state_e state_q, state_d;
  logic [LW-1:0] clr_q;
  logic          out_valid_q;

  // Request registers.
  logic               kind_q;
  logic [LW-1:0]      lk_q;
  logic [ClientW-1:0] who_q;
  logic               reply_q;
  logic [SW-1:0]      base_q;

  logic [EW-1:0]      entry_q;
  logic [ClientW-1:0] waiter_q;

  // Result registers.
  status_e            status_q;
  logic               rv_sent_q, rt_sent_q;
  logic [ClientW-1:0] rv_tgt_q, rt_tgt_q;

  logic               in_xfer, out_free;
  logic [LockIdxW-1:0] lk_rem;
  logic [LW-1:0]      lk_addr;

  // Decoded entry and its update.
  logic               e_held;
  logic [ClientW-1:0] e_owner;
  logic [HW-1:0]      e_head, head_inc, push_slot;
  logic [CW-1:0]      e_count;
  logic [CW:0]        slot_sum;
  logic               n_held;
  logic [ClientW-1:0] n_owner;
  logic [HW-1:0]      n_head;
  logic [CW-1:0]      n_count;
  status_e            r_status;
  logic               r_rv_sent, r_rt_sent;
  logic [ClientW-1:0] r_rv_tgt, r_rt_tgt;
  logic               need_pop, do_push;

  // Memory controls.
  logic               ent_we, st_we, st_re, out_load;
  logic [LW-1:0]      ent_waddr;
  logic [EW-1:0]      ent_wdata;

  assign in_ready_o = (state_q == SIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Lock index reduced into the table by conditional subtraction.
  always_comb begin
    lk_rem = lock_index_i;
    for (int k = LockIdxW - 1; k >= 0; k--) begin
      if (32'(lk_rem) >= (LOCK_COUNT << k)) begin
        lk_rem = lk_rem - LockIdxW'(LOCK_COUNT << k);
      end
    end
  end
  assign lk_addr = LW'(lk_rem);

  // Evaluation of the request against the entry read from the table.
  always_comb begin
    e_held   = entry_q[EW-1];
    e_owner  = entry_q[CW+HW+ClientW-1 -: ClientW];
    e_head   = entry_q[CW+HW-1 -: HW];
    e_count  = entry_q[CW-1:0];
    head_inc = (32'(e_head) == QUEUE_DEPTH - 1) ? '0 : e_head + HW'(1);
    slot_sum = (CW+1)'(e_head) + (CW+1)'(e_count);
    if (32'(slot_sum) >= QUEUE_DEPTH) begin
      slot_sum = slot_sum - (CW+1)'(QUEUE_DEPTH);
    end
    push_slot = HW'(slot_sum);

    n_held    = e_held;
    n_owner   = e_owner;
    n_head    = e_head;
    n_count   = e_count;
    r_status  = StOk;
    r_rv_sent = 1'b0;
    r_rv_tgt  = '0;
    r_rt_sent = 1'b0;
    r_rt_tgt  = '0;
    need_pop  = 1'b0;
    do_push   = 1'b0;

    if (!kind_q) begin
      if (!e_held) begin
        n_held  = 1'b1;
        n_owner = who_q;
      end else if (e_owner == who_q) begin
        r_status = StWrongOwner;
      end else if (e_count == CW'(QUEUE_DEPTH)) begin
        r_status = StQueueFull;
      end else if (e_count == '0) begin
        r_rv_sent = 1'b1;
        r_rv_tgt  = e_owner;
        if (!reply_q) begin
          // The requester is pushed and popped at once: it owns the lock now.
          n_owner = who_q;
          n_head  = head_inc;
        end else begin
          do_push  = 1'b1;
          n_count  = e_count + CW'(1);
          r_status = StRetry;
        end
      end else begin
        do_push  = 1'b1;
        n_count  = e_count + CW'(1);
        r_status = StRetry;
      end
    end else begin
      if (!e_held || e_owner != who_q) begin
        r_status = StWrongOwner;
      end else if (e_count != '0) begin
        need_pop  = 1'b1;
        n_owner   = waiter_q;
        n_head    = head_inc;
        n_count   = e_count - CW'(1);
        r_rt_sent = 1'b1;
        r_rt_tgt  = waiter_q;
      end else begin
        n_held = 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SClear: begin
        if (32'(clr_q) == LOCK_COUNT - 1) state_d = SIdle;
      end
      SIdle: begin
        if (in_xfer) state_d = SEntry;
      end
      SEntry: begin
        if (need_pop) state_d = SWaiter;
        else if (out_free) state_d = SIdle;
      end
      SWaiter: begin
        if (out_free) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // State machine outputs.
  always_comb begin
    ent_we    = 1'b0;
    st_we     = 1'b0;
    st_re     = 1'b0;
    out_load  = 1'b0;
    ent_waddr = lk_q;
    ent_wdata = {n_held, n_owner, n_head, n_count};
    unique case (state_q)
      SClear: begin
        ent_we    = 1'b1;
        ent_waddr = clr_q;
        ent_wdata = '0;
      end
      SIdle: ;
      SEntry: begin
        if (need_pop) begin
          st_re = 1'b1;
        end else if (out_free) begin
          ent_we   = 1'b1;
          st_we    = do_push;
          out_load = 1'b1;
        end
      end
      SWaiter: begin
        if (out_free) begin
          ent_we   = 1'b1;
          out_load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == SClear) clr_q <= clr_q + LW'(1);
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q  <= kind_i;
      lk_q    <= lk_addr;
      who_q   <= client_i;
      reply_q <= revoke_reply_i;
      base_q  <= SW'(lk_addr * QUEUE_DEPTH);
    end
    if (out_load) begin
      status_q  <= r_status;
      rv_sent_q <= r_rv_sent;
      rv_tgt_q  <= r_rv_tgt;
      rt_sent_q <= r_rt_sent;
      rt_tgt_q  <= r_rt_tgt;
    end
  end

  // Lock table: read on the request transfer, written back once per request.
  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    if (in_xfer) entry_q <= ent_mem[lk_addr];
  end

  // Waiter store: push at the tail slot, read at the head slot.
  always_ff @(posedge clk_i) begin
    if (st_we) wait_mem[base_q + SW'(push_slot)] <= who_q;
    if (st_re) waiter_q <= wait_mem[base_q + SW'(e_head)];
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign revoke_sent_o   = rv_sent_q;
  assign revoke_target_o = rv_tgt_q;
  assign retry_sent_o    = rt_sent_q;
  assign retry_target_o  = rt_tgt_q;

`ifndef SYNTHESIS
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == SEntry)
    else $error("request transfer did not start a table read");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ent_we && state_q != SClear) |-> (32'(n_count) <= QUEUE_DEPTH))
    else $error("queue count written beyond the queue depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SWaiter |-> e_count != '0)
    else $error("waiter read for an empty queue");

  a_handoff_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && retry_sent_o) |-> (status_o == StOk && !revoke_sent_o))
    else $error("hand-off result with bad status");
`endif

endmodule
